>>> sv/ttpd_pkg.sv
// Shared types and constants of the trainer telemetry packet decoder.
package ttpd_pkg;

  localparam logic [3:0] ID_SPEED   = 4'd1;
  localparam logic [3:0] ID_WATTS   = 4'd2;
  localparam logic [3:0] ID_HEART   = 4'd3;
  localparam logic [3:0] ID_CADENCE = 4'd6;
  localparam logic [3:0] ID_DRAG    = 4'd9;
  localparam logic [3:0] ID_VERSION = 4'd12;

  localparam logic [12:0] SPEED_CAP   = 13'd4950;
  localparam logic [11:0] WATTS_MAX   = 12'd3000;
  localparam logic [11:0] DRAG_MASK   = 12'h7ff;
  localparam logic [11:0] VERSION_A   = 12'd4095;
  localparam logic [11:0] VERSION_B   = 12'd3611;
  localparam logic [11:0] ERGO_LIMIT  = 12'd34;
  localparam logic [12:0] DIV100_MULT = 13'd5243;

  typedef struct packed {
    logic        parity_bad;
    logic [5:0]  keys_held;
    logic [6:0]  keys_down;
    logic [6:0]  keys_up;
    logic [3:0]  record_id;
    logic [11:0] record_value;
    logic        value_valid;
    logic [1:0]  capability_flags;
  } stat_t;

  typedef struct packed {
    stat_t           stat;
    logic [2:0][7:0] spin;
    logic [1:0]      wr_cnt;
    logic            sync;
    logic            dump;
  } entry_t;

endpackage

>>> sv/ttpd_front.sv
// Front end: accepts packets, decodes keys and records, and plans spin collection.
module ttpd_front #(
  parameter int unsigned SPIN_BARS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          spin_a_i,
  input  logic [7:0]          spin_b_i,
  input  logic [7:0]          spin_c_i,
  input  logic [7:0]          key_byte_i,
  input  logic [7:0]          id_byte_i,
  input  logic [7:0]          low_byte_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          spin_xor_value_i,
  input  logic                q_full_i,
  output logic                push_o,
  output ttpd_pkg::entry_t    entry_o
);

  localparam int unsigned CntW = $clog2(SPIN_BARS + 2);
  localparam logic [24:0] DIV100_MULT_EXT = {12'd0, ttpd_pkg::DIV100_MULT};

  logic [7:0]      xor_q;
  logic [5:0]      last_keys_q, last_keys_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            drag_q, drag_d;
  logic            ergo_q, ergo_d;

  logic            bad;
  logic [5:0]      keys;
  logic [6:0]      down, up;
  logic [3:0]      id;
  logic [3:0]      hi;
  logic [11:0]     raw;
  logic [11:0]     val;
  logic            valid;
  logic [24:0]     prod;
  logic [5:0]      quot;
  logic [11:0]     hundreds;
  logic [11:0]     rem;
  logic            sync;
  logic [CntW-1:0] cnt0, cnt1, room;
  logic            collect;
  logic [1:0]      wr_cnt;
  logic            dump;

  function automatic logic [6:0] remap(input logic [5:0] k);
    logic [6:0] m;
    begin
      m    = '0;
      m[1] = k[0];
      m[4] = k[1];
      m[5] = k[2];
      m[3] = k[3];
      m[2] = k[4];
      m[6] = k[5];
      return m;
    end
  endfunction

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    bad         = ~(^key_byte_i);
    keys        = '0;
    down        = '0;
    up          = '0;
    last_keys_d = last_keys_q;
    if (!bad) begin
      keys        = key_byte_i[5:0];
      down        = remap(keys & ~last_keys_q);
      up          = remap(~keys & last_keys_q);
      last_keys_d = keys;
    end
  end

  assign id       = id_byte_i[7:4];
  assign hi       = id_byte_i[3:0];
  assign raw      = {hi, low_byte_i};
  assign prod     = raw * DIV100_MULT_EXT;
  assign quot     = prod[24:19];
  assign hundreds = {quot, 6'd0} + {1'b0, quot, 5'd0} + {4'd0, quot, 2'd0};
  assign rem      = raw - hundreds;

  always_comb begin
    val    = raw;
    valid  = 1'b1;
    drag_d = drag_q;
    ergo_d = ergo_q;
    unique case (id)
      ttpd_pkg::ID_SPEED: begin
        if ({1'b0, raw} > ttpd_pkg::SPEED_CAP) begin
          val = ttpd_pkg::SPEED_CAP[11:0];
        end
      end
      ttpd_pkg::ID_WATTS: begin
        if (raw > ttpd_pkg::WATTS_MAX) begin
          val = '0;
        end
      end
      ttpd_pkg::ID_HEART: begin
        if (hi[1] || (hi[3:2] == 2'b11)) begin
          valid = 1'b0;
        end
      end
      ttpd_pkg::ID_CADENCE: begin
        valid = hi[3];
      end
      ttpd_pkg::ID_DRAG: begin
        val = raw & ttpd_pkg::DRAG_MASK;
      end
      ttpd_pkg::ID_VERSION: begin
        drag_d = (raw == ttpd_pkg::VERSION_A) || (raw == ttpd_pkg::VERSION_B);
        if (rem <= ttpd_pkg::ERGO_LIMIT) begin
          ergo_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sync    = key_byte_i[6];
    cnt0    = sync ? '0 : fill_q;
    room    = CntW'(SPIN_BARS) - cnt0;
    collect = (cnt0 < CntW'(SPIN_BARS)) && (spin_a_i != 8'd0);
    wr_cnt  = '0;
    if (collect) begin
      wr_cnt = (room >= CntW'(3)) ? 2'd3 : room[1:0];
    end
    cnt1   = cnt0 + CntW'(wr_cnt);
    dump   = (cnt1 == CntW'(SPIN_BARS));
    fill_d = dump ? CntW'(SPIN_BARS + 1) : cnt1;
  end

  always_comb begin
    entry_o.stat.parity_bad       = bad;
    entry_o.stat.keys_held        = keys;
    entry_o.stat.keys_down        = down;
    entry_o.stat.keys_up          = up;
    entry_o.stat.record_id        = id;
    entry_o.stat.record_value     = val;
    entry_o.stat.value_valid      = valid;
    entry_o.stat.capability_flags = {ergo_d, drag_d};
    entry_o.spin[0]               = spin_a_i ^ xor_q;
    entry_o.spin[1]               = spin_b_i ^ xor_q;
    entry_o.spin[2]               = spin_c_i ^ xor_q;
    entry_o.wr_cnt                = wr_cnt;
    entry_o.sync                  = sync;
    entry_o.dump                  = dump;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= '0;
      last_keys_q <= '0;
      fill_q      <= CntW'(SPIN_BARS + 1);
      drag_q      <= 1'b0;
      ergo_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        xor_q <= spin_xor_value_i;
      end
      if (push_o) begin
        last_keys_q <= last_keys_d;
        fill_q      <= fill_d;
        drag_q      <= drag_d;
        ergo_q      <= ergo_d;
      end
    end
  end

endmodule

>>> sv/ttpd_queue.sv
// Two-entry queue that decouples the front end from the back end.
module ttpd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ttpd_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ttpd_pkg::entry_t entry_o
);

  ttpd_pkg::entry_t slots_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> sv/ttpd_back.sv
// Back end: stores spin bytes, emits the status result and unpacks spin bars.
module ttpd_back #(
  parameter int unsigned SPIN_BARS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  ttpd_pkg::entry_t             entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output ttpd_pkg::stat_t              stat_o,
  output logic [$clog2(SPIN_BARS)-1:0] bar_index_o,
  output logic [14:0]                  bar_value_o,
  output logic                         last_o
);

  localparam int unsigned IdxW = $clog2(SPIN_BARS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_SHOW
  } state_e;

  state_e          state_q;
  logic [7:0]      mem [SPIN_BARS];
  logic [7:0]      rd_data_q;
  logic [2:0][7:0] bytes_q;
  logic [1:0]      left_q;
  logic [1:0]      sel_q;
  logic            dump_q;
  logic [IdxW-1:0] wr_addr_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            out_valid_q;
  logic            kind_q;
  ttpd_pkg::stat_t stat_q;
  logic [IdxW-1:0] bar_idx_q;
  logic [14:0]     bar_val_q;
  logic            last_q;
  logic            out_free;
  logic            mem_we;
  logic            bar_last;

  function automatic logic [14:0] unpack_bar(input logic [7:0] b);
    logic [14:0] m;
    begin
      m = {7'd0, b[7:3], 3'd0};
      if (b[2:0] == 3'd0) begin
        return m;
      end
      return (m | 15'h100) << (b[2:0] - 3'd1);
    end
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i && out_free;
  assign mem_we   = (state_q == S_WRITE) && (left_q != 2'd0);
  assign bar_last = (rd_idx_q == IdxW'(SPIN_BARS - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr_q] <= bytes_q[sel_q];
    end
    if (state_q == S_READ) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      sel_q       <= '0;
      dump_q      <= 1'b0;
      wr_addr_q   <= '0;
      rd_idx_q    <= '0;
      bytes_q     <= '0;
      kind_q      <= 1'b0;
      stat_q      <= '0;
      bar_idx_q   <= '0;
      bar_val_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            out_valid_q <= 1'b1;
            kind_q      <= 1'b0;
            stat_q      <= entry_i.stat;
            bar_idx_q   <= '0;
            bar_val_q   <= '0;
            last_q      <= !entry_i.dump;
            bytes_q     <= entry_i.spin;
            left_q      <= entry_i.wr_cnt;
            sel_q       <= '0;
            dump_q      <= entry_i.dump;
            if (entry_i.sync) begin
              wr_addr_q <= '0;
            end
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (left_q != 2'd0) begin
            left_q    <= left_q - 2'd1;
            sel_q     <= sel_q + 2'd1;
            wr_addr_q <= wr_addr_q + IdxW'(1);
          end else if (dump_q) begin
            rd_idx_q <= '0;
            state_q  <= S_READ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= 1'b1;
            stat_q      <= '0;
            bar_idx_q   <= rd_idx_q;
            bar_val_q   <= unpack_bar(rd_data_q);
            last_q      <= bar_last;
            if (bar_last) begin
              state_q <= S_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q + IdxW'(1);
              state_q  <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign stat_o        = stat_q;
  assign bar_index_o   = bar_idx_q;
  assign bar_value_o   = bar_val_q;
  assign last_o        = last_q;

endmodule

>>> sv/trainer_telemetry_packet_decoder.sv
// Top level of the trainer telemetry packet decoder.
// Each accepted packet gives one status result, and a packet that completes the
// spin store is followed by SPIN_BARS bar results. The front end takes a packet
// whenever its two-entry queue has room. The back end pops a packet when idle,
// then writes its spin bytes one at a time, since the spin store has a single
// write port; each bar of a dump needs the registered store read and is then
// shown once the output register is free. The output register lets the next
// transfer be prepared while a result waits.
module trainer_telemetry_packet_decoder #(
  parameter int unsigned SPIN_BARS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   spin_a_i,
  input  logic [7:0]                   spin_b_i,
  input  logic [7:0]                   spin_c_i,
  input  logic [7:0]                   key_byte_i,
  input  logic [7:0]                   id_byte_i,
  input  logic [7:0]                   low_byte_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   spin_xor_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output logic                         parity_bad_o,
  output logic [5:0]                   keys_held_o,
  output logic [6:0]                   keys_down_o,
  output logic [6:0]                   keys_up_o,
  output logic [3:0]                   record_id_o,
  output logic [11:0]                  record_value_o,
  output logic                         value_valid_o,
  output logic [1:0]                   capability_flags_o,
  output logic [$clog2(SPIN_BARS)-1:0] bar_index_o,
  output logic [14:0]                  bar_value_o,
  output logic                         last_o
);

  ttpd_pkg::entry_t push_entry;
  ttpd_pkg::entry_t pop_entry;
  ttpd_pkg::stat_t  stat;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  ttpd_front #(
    .SPIN_BARS(SPIN_BARS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .spin_a_i        (spin_a_i),
    .spin_b_i        (spin_b_i),
    .spin_c_i        (spin_c_i),
    .key_byte_i      (key_byte_i),
    .id_byte_i       (id_byte_i),
    .low_byte_i      (low_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .spin_xor_value_i(spin_xor_value_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  ttpd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .entry_o(pop_entry)
  );

  ttpd_back #(
    .SPIN_BARS(SPIN_BARS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .stat_o       (stat),
    .bar_index_o  (bar_index_o),
    .bar_value_o  (bar_value_o),
    .last_o       (last_o)
  );

  assign parity_bad_o       = stat.parity_bad;
  assign keys_held_o        = stat.keys_held;
  assign keys_down_o        = stat.keys_down;
  assign keys_up_o          = stat.keys_up;
  assign record_id_o        = stat.record_id;
  assign record_value_o     = stat.record_value;
  assign value_valid_o      = stat.value_valid;
  assign capability_flags_o = stat.capability_flags;

endmodule
